>>> rtl/core/stfcs_pkg.sv
// ----------------------------------------------------------------------------
// stfcs_pkg
// shared types and constants of the sorted table floor/ceiling search unit
// ----------------------------------------------------------------------------
package stfcs_pkg;

    localparam int unsigned DEF_TABLE_DEPTH = 1024;
    localparam int unsigned DATA_W          = 32;
    localparam int unsigned OPCODE_W        = 2;
    localparam int unsigned IN_TDATA_W      = 32;
    localparam int unsigned OUT_TDATA_W     = 72;

    // opcodes carried on the input tuser
    localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic append;
        logic clear;
        logic start;
        logic probe;
        logic compare;
        logic emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic search_open;
        logic hit;
    } t_dp_stat;

endpackage

>>> rtl/core/stfcs_ctrl.sv
// ----------------------------------------------------------------------------
// stfcs_ctrl
// sequencer for append, clear and the binary search probe loop
// ----------------------------------------------------------------------------
module stfcs_ctrl
    import stfcs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [OPCODE_W-1:0] i_in_opcode,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  t_dp_stat            i_stat,
    output t_dp_cmd             o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_CMP,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd.append  = accept && (i_in_opcode == OP_APPEND);
        o_cmd.clear   = accept && (i_in_opcode == OP_CLEAR);
        o_cmd.start   = accept && (i_in_opcode == OP_QUERY);
        o_cmd.probe   = (r_state == S_SEARCH) && i_stat.search_open;
        o_cmd.compare = (r_state == S_CMP);
        o_cmd.emit    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.start) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                n_state = i_stat.search_open ? S_CMP : S_DONE;
            end
            S_CMP: begin
                n_state = i_stat.hit ? S_DONE : S_SEARCH;
            end
            S_DONE: begin
                if (o_cmd.emit) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> rtl/core/stfcs_dpath.sv
// ----------------------------------------------------------------------------
// stfcs_dpath
// table memory, search bounds, floor/ceiling candidates and result register
// ----------------------------------------------------------------------------
module stfcs_dpath
    import stfcs_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic signed [DATA_W-1:0] i_value,
    output t_dp_stat                 o_stat,
    output logic signed [DATA_W-1:0] o_floor_value,
    output logic                     o_floor_valid,
    output logic signed [DATA_W-1:0] o_ceil_value,
    output logic                     o_ceil_valid,
    output logic                     o_overflow
);

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    logic signed [DATA_W-1:0] r_mem [TABLE_DEPTH];

    logic [CNT_W-1:0]         r_count;
    logic                     r_dropped;
    logic [CNT_W-1:0]         r_lo;
    logic [CNT_W-1:0]         r_hix;     // one past the upper bound
    logic [CNT_W-1:0]         r_mid;
    logic [CNT_W-1:0]         n_mid;
    logic signed [DATA_W-1:0] r_key;
    logic signed [DATA_W-1:0] r_rdata;
    logic                     r_fv;
    logic                     r_cv;
    logic signed [DATA_W-1:0] r_fl;
    logic signed [DATA_W-1:0] r_ce;
    logic                     full;
    logic                     above;

    assign full               = (r_count == DEPTH_C);
    assign n_mid              = r_lo + ((r_hix - r_lo - ONE_C) >> 1);
    assign above              = (r_rdata > r_key);
    assign o_stat.search_open = (r_lo < r_hix);
    assign o_stat.hit         = (r_rdata == r_key);

    // table storage, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !full) begin
            r_mem[r_count[IDX_W-1:0]] <= i_value;
        end
        if (i_cmd.probe) begin
            r_rdata <= r_mem[n_mid[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.clear) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.append) begin
            if (full) begin
                r_dropped <= 1'b1;
            end else begin
                r_count <= r_count + ONE_C;
            end
        end
    end

    // search bounds and candidates
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_lo  <= '0;
            r_hix <= r_count;
            r_key <= i_value;
            r_fv  <= 1'b0;
            r_cv  <= 1'b0;
            r_fl  <= '0;
            r_ce  <= '0;
        end
        if (i_cmd.probe) begin
            r_mid <= n_mid;
        end
        if (i_cmd.compare) begin
            if (o_stat.hit) begin
                r_fv <= 1'b1;
                r_cv <= 1'b1;
                r_fl <= r_key;
                r_ce <= r_key;
            end else if (above) begin
                if (!r_cv || (r_rdata < r_ce)) begin
                    r_cv <= 1'b1;
                    r_ce <= r_rdata;
                end
                r_hix <= r_mid;
            end else begin
                if (!r_fv || (r_rdata > r_fl)) begin
                    r_fv <= 1'b1;
                    r_fl <= r_rdata;
                end
                r_lo <= r_mid + ONE_C;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_floor_value <= r_fl;
            o_floor_valid <= r_fv;
            o_ceil_value  <= r_ce;
            o_ceil_valid  <= r_cv;
            o_overflow    <= r_dropped;
        end
    end

endmodule

>>> rtl/core/sorted_table_floor_ceiling_search_unit.sv
// ----------------------------------------------------------------------------
// sorted_table_floor_ceiling_search_unit
// floor and ceiling lookup over an ascending table by binary search
// ----------------------------------------------------------------------------
// The unit holds up to TABLE_DEPTH signed 32-bit values that are appended in
// ascending order. Opcode append (tuser 0) stores tdata at the end of the
// table, or drops it and raises the sticky overflow flag when the table is
// full. Opcode clear (tuser 1) empties the table and clears overflow. Opcode
// query (tuser 2) binary-searches for the key in tdata and returns one output
// word with the floor and the ceiling, each with a valid flag; an exact match
// gives the key for both, and a missing answer reads 0. Opcode 3 is ignored.
// Append and clear give no output word. Each probe of a query reads the table
// memory through a registered port before its compare; after the last probe
// comes a closing bound check, skipped on an exact match, and then the load of
// the output register. The unit then returns to idle and takes the next word,
// so a query holds the input until its answer is loaded, and longer while an
// earlier word is still unread. Items are taken one at a time; the finished
// word sits in the output register, so the next item is accepted while it
// waits. No clearing pass follows reset: only entries below the fill count are
// ever read. Answers for a table that was loaded out of order are deterministic
// but need not be the true floor or ceiling.
// ----------------------------------------------------------------------------
module sorted_table_floor_ceiling_search_unit
    import stfcs_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input words
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] value
    input  logic [OPCODE_W-1:0]    s_axis_tuser,   // [1:0] opcode
    // result words
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [31:0] floor_value,
                                                   // [32] floor_valid,
                                                   // [64:33] ceil_value,
                                                   // [65] ceil_valid,
                                                   // [66] overflow,
                                                   // [71:67] zero
);

    t_dp_cmd                  cmd;
    t_dp_stat                 stat;
    logic signed [DATA_W-1:0] floor_value;
    logic                     floor_valid;
    logic signed [DATA_W-1:0] ceil_value;
    logic                     ceil_valid;
    logic                     overflow;

    // sequencer: accepts words while idle, walks the probe loop
    stfcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_opcode (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // table memory, bounds, candidates and result register
    stfcs_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_value       ($signed(s_axis_tdata[DATA_W-1:0])),
        .o_stat        (stat),
        .o_floor_value (floor_value),
        .o_floor_valid (floor_valid),
        .o_ceil_value  (ceil_value),
        .o_ceil_valid  (ceil_valid),
        .o_overflow    (overflow)
    );

    // pack the result word, highest field first
    assign m_axis_tdata = {5'b0, overflow, ceil_valid, ceil_value, floor_valid, floor_value};

    // a missing floor reads as zero
    a_floor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[32]) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("floor value not zero while floor invalid");

    // floor never lies above the ceiling when both are present
    a_floor_le_ceil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[32] && m_axis_tdata[65])
            |-> ($signed(m_axis_tdata[31:0]) <= $signed(m_axis_tdata[64:33])))
        else $error("floor above ceiling");

    // a query holds off the next input word while the search runs
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_QUERY))
            |=> !s_axis_tready)
        else $error("input accepted during a search");

endmodule
